>>> rtl/core/mrc_pkg.sv
// Shared types, constants and helpers for the memory range coalescer.
`default_nettype none

package mrc_pkg;

	localparam int MAP_SLOTS = 256;
	localparam int SLOT_CNT_W = 9;
	localparam int ADDR_W = 64;
	localparam int TYPE_W = 32;
	localparam int SLOT_W = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_REGION_TYPE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SLOT = CFG_IDX_W'(1);

	localparam logic [SLOT_CNT_W-1:0] SLOT_LIMIT = SLOT_CNT_W'(MAP_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(MAP_SLOTS - 1);

	typedef struct packed {
		logic [TYPE_W-1:0] etype;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic [SLOT_W-1:0] slot;
		logic              full;
		logic              last;
	} entry_t;

	function automatic logic slot_full(input logic [SLOT_CNT_W-1:0] cnt);
		return cnt >= SLOT_LIMIT;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_value(input logic [SLOT_CNT_W-1:0] cnt);
		return slot_full(cnt) ? SLOT_TOP : cnt[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_CNT_W-1:0] slot_advance(input logic [SLOT_CNT_W-1:0] cnt);
		return slot_full(cnt) ? cnt : cnt + SLOT_CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/mrc_merge.sv
// Run tracking, merge decision and map entry formation for one region per cycle.
`default_nettype none

module mrc_merge
	import mrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  item_valid,
	input  wire logic [ADDR_W-1:0]     item_start,
	input  wire logic [ADDR_W-1:0]     item_size,
	input  wire logic                  item_last,
	output logic [1:0]                 push_n,
	output entry_t                     push_a,
	output entry_t                     push_b
);

	logic [TYPE_W-1:0]     region_type_q;
	logic [SLOT_W-1:0]     first_slot_q;
	logic                  run_open_q;
	logic [ADDR_W-1:0]     run_start_q;
	logic [ADDR_W-1:0]     run_size_q;
	logic [SLOT_CNT_W-1:0] next_slot_q;

	logic [ADDR_W-1:0]     run_end;
	logic                  join_run;
	logic                  close_run;
	logic [ADDR_W-1:0]     new_start;
	logic [ADDR_W-1:0]     new_size;
	logic [SLOT_CNT_W-1:0] slot_after_close;
	entry_t                close_e;
	entry_t                flush_e;

	always_comb begin
		run_end = run_start_q + run_size_q;
		join_run = run_open_q && (item_start == run_end);
		close_run = run_open_q && !join_run;
		new_start = join_run ? run_start_q : item_start;
		new_size = join_run ? (run_size_q + item_size) : item_size;
		slot_after_close = close_run ? slot_advance(next_slot_q) : next_slot_q;

		close_e.etype = region_type_q;
		close_e.start = run_start_q;
		close_e.size = run_size_q;
		close_e.slot = slot_value(next_slot_q);
		close_e.full = slot_full(next_slot_q);
		close_e.last = 1'b0;

		flush_e.etype = region_type_q;
		flush_e.start = new_start;
		flush_e.size = new_size;
		flush_e.slot = slot_value(slot_after_close);
		flush_e.full = slot_full(slot_after_close);
		flush_e.last = 1'b1;

		push_n = 2'd0;
		push_a = close_run ? close_e : flush_e;
		push_b = flush_e;
		if (item_valid) begin
			push_n = 2'({1'b0, close_run} + {1'b0, item_last});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_type_q <= TYPE_W'(1);
			first_slot_q <= '0;
			run_open_q <= 1'b0;
			run_start_q <= '0;
			run_size_q <= '0;
			next_slot_q <= '0;
		end else begin
			if (item_valid) begin
				if (item_last) begin
					run_open_q <= 1'b0;
					run_start_q <= '0;
					run_size_q <= '0;
					next_slot_q <= SLOT_CNT_W'(first_slot_q);
				end else begin
					run_open_q <= 1'b1;
					run_start_q <= new_start;
					run_size_q <= new_size;
					next_slot_q <= slot_after_close;
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_REGION_TYPE: begin
						region_type_q <= cfg_wdata[TYPE_W-1:0];
					end
					REG_FIRST_SLOT: begin
						first_slot_q <= cfg_wdata[SLOT_W-1:0];
						next_slot_q <= SLOT_CNT_W'(cfg_wdata[SLOT_W-1:0]);
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_last && !cfg_we |=> !run_open_q)
		else $error("run still open after the final region");

	a_two_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> item_last && run_open_q)
		else $error("two entries from a region that is not last");

	a_no_entry_without_run: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_last && !run_open_q |-> push_n == 2'd0)
		else $error("entry emitted with no open run");

endmodule

`default_nettype wire

>>> rtl/core/mrc_out_fifo.sv
// Result queue that takes up to two map entries per cycle and delivers one per beat.
`default_nettype none

module mrc_out_fifo
	import mrc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  [1:0] push_n,
	input  wire entry_t push_a,
	input  wire entry_t push_b,
	output logic       room2,
	output logic       out_valid,
	input  wire logic  out_stall,
	output entry_t     out_entry
);

	entry_t                mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 pop;

	always_comb begin
		out_valid = count_q != '0;
		out_entry = mem_q[rd_ptr_q];
		pop = out_valid && !out_stall;
		room2 = count_q <= OUT_CNT_W'(OUT_DEPTH - 2);
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + OUT_PTR_W'(1)] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			count_q <= count_q + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room2)
		else $error("entries pushed into a full result queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == 2'd0 |=> count_q == $past(count_q) - OUT_CNT_W'(1))
		else $error("result queue count lost a beat");

endmodule

`default_nettype wire

>>> rtl/core/memory_range_coalescer.sv
// Top level of the memory range coalescer: input register, merge logic and result queue.
`default_nettype none

// Regions enter on the region channel, one beat per cycle, and pass one input
// register; the merge against the open run (one 64-bit end-address add and
// compare) works on that register once the queue has room for two entries,
// and the resulting map entries go into a four-entry result queue that drives
// the entry channel. A region that closes a run yields one entry, the final
// region of a list yields one or two, and a region that joins the run yields
// none. Sustained rate is one region per cycle while the queue has room; a
// final region can produce two entries, so the region channel stalls when the
// queue holds more than two entries. Entries pass the input register and the
// result queue on their way to the entry channel. The configuration channel is
// always ready; writing first_slot also restarts the slot counter.
module memory_range_coalescer
	import mrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  region_valid,
	output logic                       region_stall,
	input  wire logic [ADDR_W-1:0]     region_start,
	input  wire logic [ADDR_W-1:0]     region_size,
	input  wire logic                  last_region,
	output logic                       entry_valid,
	input  wire logic                  entry_stall,
	output logic [TYPE_W-1:0]          entry_type,
	output logic [ADDR_W-1:0]          entry_start,
	output logic [ADDR_W-1:0]          entry_size,
	output logic [SLOT_W-1:0]          entry_slot,
	output logic                       table_full,
	output logic                       last_entry
);

	logic              valid_s1;
	logic [ADDR_W-1:0] start_s1;
	logic [ADDR_W-1:0] size_s1;
	logic              last_s1;
	logic              room2;
	logic              proc;
	logic              accept;
	logic [1:0]        push_n;
	entry_t            push_a;
	entry_t            push_b;
	entry_t            head;

	always_comb begin
		cfg_ready = 1'b1;
		proc = valid_s1 && room2;
		region_stall = valid_s1 && !room2;
		accept = region_valid && !region_stall;
		entry_type = head.etype;
		entry_start = head.start;
		entry_size = head.size;
		entry_slot = head.slot;
		table_full = head.full;
		last_entry = head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= region_start;
			size_s1 <= region_size;
			last_s1 <= last_region;
		end
	end

	mrc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.item_valid (proc),
		.item_start (start_s1),
		.item_size  (size_s1),
		.item_last  (last_s1),
		.push_n     (push_n),
		.push_a     (push_a),
		.push_b     (push_b)
	);

	mrc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (push_a),
		.push_b    (push_b),
		.room2     (room2),
		.out_valid (entry_valid),
		.out_stall (entry_stall),
		.out_entry (head)
	);

endmodule

`default_nettype wire

>>> sim/memory_range_coalescer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the memory range coalescer, with its own region-merging predictor.
module memory_range_coalescer_tb;
	import mrc_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic              last;
	} region_t;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
	localparam int HOLD_CYCLES = 160;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  region_valid = 1'b0;
	logic                  region_stall;
	logic [ADDR_W-1:0]     region_start = '0;
	logic [ADDR_W-1:0]     region_size = '0;
	logic                  last_region = 1'b0;
	logic                  entry_valid;
	logic                  entry_stall = 1'b0;
	logic [TYPE_W-1:0]     entry_type;
	logic [ADDR_W-1:0]     entry_start;
	logic [ADDR_W-1:0]     entry_size;
	logic [SLOT_W-1:0]     entry_slot;
	logic                  table_full;
	logic                  last_entry;

	memory_range_coalescer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.region_valid(region_valid),
		.region_stall(region_stall),
		.region_start(region_start),
		.region_size(region_size),
		.last_region(last_region),
		.entry_valid(entry_valid),
		.entry_stall(entry_stall),
		.entry_type(entry_type),
		.entry_start(entry_start),
		.entry_size(entry_size),
		.entry_slot(entry_slot),
		.table_full(table_full),
		.last_entry(last_entry)
	);

	region_t region_pending[$];
	entry_t  entry_expect_q[$];

	// Predictor state and its copy of the registers.
	logic [TYPE_W-1:0]     cur_type = 32'd1;
	logic [SLOT_W-1:0]     cur_first = '0;
	logic [SLOT_CNT_W-1:0] slot_ctr = '0;
	logic                  run_live = 1'b0;
	logic [ADDR_W-1:0]     run_base = '0;
	logic [ADDR_W-1:0]     run_len = '0;

	int mismatches = 0;
	int regions_taken = 0;
	int entries_seen = 0;
	int joins = 0;
	int double_flushes = 0;
	int full_entries = 0;
	int wrapped_ends = 0;
	int cfg_writes = 0;
	int long_holds = 0;

	int gap_left = 0;
	int burst_left = 0;

	int rx_seen = 0;
	int hold_left = 0;
	int rx_cycle = 0;
	rx_mode_t rx_mode = RX_FREE;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	function automatic void emit_entry(input logic is_last);
		entry_t e;
		e.etype = cur_type;
		e.start = run_base;
		e.size = run_len;
		e.full = slot_ctr >= SLOT_LIMIT;
		e.slot = e.full ? SLOT_TOP : slot_ctr[SLOT_W-1:0];
		e.last = is_last;
		entry_expect_q.push_back(e);
		if (e.full)
			full_entries++;
		else
			slot_ctr = slot_ctr + 1'b1;
	endfunction

	function automatic void coalesce_region(input region_t r);
		int depth0;
		logic [ADDR_W:0] end_sum;
		depth0 = entry_expect_q.size();
		end_sum = {1'b0, r.start} + {1'b0, r.size};
		if (end_sum[ADDR_W])
			wrapped_ends++;
		if (run_live && r.start == run_base + run_len) begin
			run_len = run_len + r.size;
			joins++;
		end else begin
			if (run_live)
				emit_entry(1'b0);
			run_live = 1'b1;
			run_base = r.start;
			run_len = r.size;
		end
		if (r.last) begin
			emit_entry(1'b1);
			run_live = 1'b0;
			run_base = '0;
			run_len = '0;
			slot_ctr = {1'b0, cur_first};
		end
		if (entry_expect_q.size() - depth0 == 2)
			double_flushes++;
	endfunction

	// Checks the output beat first, then applies register writes and predicts accepted regions.
	always @(posedge clk) begin : monitor
		entry_t want;
		if (arst_n) begin
			if (entry_valid && !entry_stall) begin
				entries_seen++;
				if (entry_expect_q.size() == 0) begin
					report_mismatch("unexpected entry start", entry_start, '0);
				end else begin
					want = entry_expect_q.pop_front();
					if (entry_type !== want.etype)
						report_mismatch("entry_type", entry_type, want.etype);
					if (entry_start !== want.start)
						report_mismatch("entry_start", entry_start, want.start);
					if (entry_size !== want.size)
						report_mismatch("entry_size", entry_size, want.size);
					if (entry_slot !== want.slot)
						report_mismatch("entry_slot", entry_slot, want.slot);
					if (table_full !== want.full)
						report_mismatch("table_full", table_full, want.full);
					if (last_entry !== want.last)
						report_mismatch("last_entry", last_entry, want.last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				if (cfg_index == REG_REGION_TYPE) begin
					cur_type = cfg_data;
				end else if (cfg_index == REG_FIRST_SLOT) begin
					cur_first = cfg_data[SLOT_W-1:0];
					slot_ctr = {1'b0, cfg_data[SLOT_W-1:0]};
				end
			end
			if (region_valid && !region_stall) begin
				regions_taken++;
				coalesce_region('{region_start, region_size, last_region});
			end
		end
	end

	// Sends pending regions in bursts with random gaps between them.
	always @(posedge clk) begin : driver
		region_t nxt;
		if (arst_n && (!region_valid || !region_stall)) begin
			if (gap_left > 0) begin
				gap_left--;
				region_valid <= 1'b0;
			end else if (region_pending.size() > 0) begin
				nxt = region_pending.pop_front();
				region_valid <= 1'b1;
				region_start <= nxt.start;
				region_size <= nxt.size;
				last_region <= nxt.last;
				if (burst_left > 1) begin
					burst_left--;
				end else if ($urandom_range(0, 4) == 0) begin
					burst_left = $urandom_range(30, 80);
					gap_left = 0;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = $urandom_range(0, 10);
				end
			end else begin
				region_valid <= 1'b0;
			end
		end
	end

	// Stalls the entry channel on a changing pattern, with long hold-offs while regions flow.
	always @(posedge clk) begin : receiver
		rx_cycle++;
		if (region_valid && !region_stall)
			rx_seen++;
		if (hold_left > 0) begin
			hold_left--;
			entry_stall <= 1'b1;
		end else if (rx_seen == 300 || rx_seen == 750) begin
			hold_left = HOLD_CYCLES;
			long_holds++;
			rx_seen++;
			entry_stall <= 1'b1;
		end else begin
			if (rx_cycle % 64 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_FREE: entry_stall <= 1'b0;
				RX_LIGHT: entry_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: entry_stall <= ($urandom_range(0, 3) != 0);
				default: entry_stall <= ~entry_stall;
			endcase
		end
	end

	task automatic add_region(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] size,
			input logic last);
		region_t r;
		r.start = start;
		r.size = size;
		r.last = last;
		region_pending.push_back(r);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (region_pending.size() != 0 || region_valid || entry_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random_lists(input int count);
		int left;
		int len;
		int k;
		int pick;
		logic [ADDR_W-1:0] prev_end;
		region_t r;
		left = count;
		prev_end = rand64();
		@(negedge clk);
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
			if (len > left)
				len = left;
			for (k = 0; k < len; k++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					r.start = prev_end;
				else if (pick < 8)
					r.start = rand64();
				else if (pick == 8)
					r.start = ADDR_MAX - $urandom_range(0, 64);
				else
					r.start = prev_end + $urandom_range(1, 16);
				pick = $urandom_range(0, 9);
				if (pick < 4)
					r.size = $urandom_range(0, 4096);
				else if (pick == 4)
					r.size = '0;
				else if (pick == 5)
					r.size = rand64();
				else if (pick == 6)
					r.size = ADDR_MAX - $urandom_range(0, 64);
				else if (pick == 7)
					r.size = 64'd1 << $urandom_range(0, 63);
				else
					r.size = 64'(($urandom_range(1, 256))) << 12;
				// Most lists end properly; some are cut short and a few end early.
				r.last = (k == len - 1) ? ($urandom_range(0, 7) != 0)
					: ($urandom_range(0, 30) == 0);
				region_pending.push_back(r);
				prev_end = r.start + r.size;
			end
			left -= len;
		end
	endtask

	initial begin : stimulus
		int i;
		logic [ADDR_W-1:0] base;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		add_region(64'd0, 64'd0, 1'b0);
		add_region(64'd0, 64'd5, 1'b0);
		add_region(64'd5, 64'd0, 1'b0);
		add_region(64'd5, 64'd16, 1'b0);
		add_region(64'd100, 64'd10, 1'b0);
		add_region(64'd110, 64'd1, 1'b1);
		add_region(64'd7, 64'd3, 1'b1);
		add_region(ADDR_MAX - 64'd15, 64'd32, 1'b0);
		add_region(64'd16, 64'd1, 1'b0);
		add_region(64'd17, ADDR_MAX, 1'b0);
		add_region(ADDR_MAX, ADDR_MAX, 1'b1);
		add_region(ADDR_MAX, 64'd0, 1'b0);
		add_region(ADDR_MAX, 64'd1, 1'b0);
		add_region(64'd0, ADDR_MAX, 1'b0);
		add_region(ADDR_MAX, 64'd0, 1'b1);
		add_region(64'd0, 64'd0, 1'b1);
		add_region(rand64(), ADDR_MAX, 1'b0);
		add_region(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1);
		add_region(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		add_region(ADDR_MAX, 64'h5555_5555_5555_5555, 1'b0);
		add_region(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
		wait_idle();

		// Start near the top of the table so the slot number saturates.
		write_reg(REG_REGION_TYPE, '1);
		write_reg(REG_FIRST_SLOT, 32'hABCD_EFFA);
		write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
		@(negedge clk);
		for (i = 0; i < 14; i++)
			add_region(64'h1000 * i, 64'h10, i == 13);
		for (i = 0; i < 4; i++)
			add_region(64'h9000 + 64'h100 * i, 64'h40, 1'b0);
		wait_idle();

		// Rewrite both registers with a list still open.
		write_reg(REG_FIRST_SLOT, 32'd3);
		write_reg(REG_REGION_TYPE, '0);
		@(negedge clk);
		add_region(64'h9340, 64'h10, 1'b0);
		add_region(64'hA000, 64'h10, 1'b0);
		add_region(64'hB000, 64'h10, 1'b1);
		wait_idle();

		for (i = 0; i < 4; i++) begin
			case (i)
				0: begin
					write_reg(REG_REGION_TYPE, $urandom);
					write_reg(REG_FIRST_SLOT, $urandom);
				end
				1: begin
					write_reg(REG_REGION_TYPE, '1);
					write_reg(REG_FIRST_SLOT, '1);
				end
				2: begin
					write_reg(REG_REGION_TYPE, '0);
					write_reg(REG_FIRST_SLOT, 32'hFFFF_FF00);
				end
				default: begin
					write_reg(REG_REGION_TYPE, $urandom);
					write_reg(REG_FIRST_SLOT, $urandom_range(200, 250));
				end
			endcase
			write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
			queue_random_lists(190);
			wait_idle();
		end

		// One list longer than the table, counted from slot zero.
		write_reg(REG_FIRST_SLOT, '0);
		@(negedge clk);
		base = rand64();
		for (i = 0; i < 262; i++)
			add_region(base + 64'h100 * i, 64'h10 + $urandom_range(0, 64), i == 261);
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Covered %0d regions and %0d map entries: %0d merges, %0d two-entry flushes,",
			regions_taken, entries_seen, joins, double_flushes);
		$display("%0d saturated slots, %0d wrapped ends, %0d register writes, %0d long hold-offs.",
			full_entries, wrapped_ends, cfg_writes, long_holds);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Timed out with %0d entries outstanding.", entry_expect_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
